FILE: sv/scct_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the swept circle collision test
package scct_pkg;

  // datapath coordinate width and radius width
  localparam int DW    = 16;
  localparam int RW    = 15;
  localparam int STW   = 16;            // step time, q0.16
  localparam int DIFW  = DW + 1;        // relative position / velocity
  localparam int PRW   = 2 * DIFW;      // signed 17x17 products
  localparam int SW    = PRW + 2;       // sums of products
  localparam int MW    = 2 * DW + 1;    // magnitudes of p, -a and v
  localparam int LOW   = 17;            // low slice for split multiplies
  localparam int HIW   = MW - LOW;      // high slice
  localparam int SNW   = STW + MW;      // s*n and s*v
  localparam int NNW   = 2 * MW;        // n*n and p*v
  localparam int SUMW  = 2 * STW + MW + 2;  // s*s*v + p*2^32
  localparam int RSH   = STW + 1;       // s*n*2^17

  typedef enum logic [2:0] {
    OUT_OFFSCREEN  = 3'd0,
    OUT_OVERLAP    = 3'd1,
    OUT_SEPARATE   = 3'd2,
    OUT_CLEAR      = 3'd3,
    OUT_DISC_HIT   = 3'd4,
    OUT_DISC_MISS  = 3'd5
  } outcome_e;

  typedef struct packed {
    logic signed [DW-1:0] p1x;
    logic signed [DW-1:0] p1y;
    logic signed [DW-1:0] v1x;
    logic signed [DW-1:0] v1y;
    logic [RW-1:0]        r1;
    logic signed [DW-1:0] p2x;
    logic signed [DW-1:0] p2y;
    logic signed [DW-1:0] v2x;
    logic signed [DW-1:0] v2y;
    logic [RW-1:0]        r2;
  } pair_t;

  // early decision plus the magnitudes for the quadratic tests
  typedef struct packed {
    logic          done;
    outcome_e      code;
    logic [MW-1:0] n;
    logic [MW-1:0] up;
    logic [MW-1:0] uv;
  } quad_t;

  // everything the final decision needs
  typedef struct packed {
    logic            done;
    outcome_e        code;
    logic            c1;
    logic            disc;
    logic [SUMW-1:0] lhs;
    logic [SNW-1:0]  sn;
  } cmp_t;

endpackage

FILE: sv/scct_geom.sv
`timescale 1ns / 1ps
// front stages: offscreen test, differences, squares and dot products
module scct_geom import scct_pkg::*; (
  input  logic            clk_i,
  input  logic [2:0]      en_i,
  input  pair_t           pair_i,
  input  logic [RW-1:0]   world_width_i,
  input  logic [RW-1:0]   world_height_i,
  input  logic [STW-1:0]  step_seconds_i,
  output quad_t           quad_o
);

  function automatic logic is_off(logic signed [DW-1:0] x, logic signed [DW-1:0] y,
                                  logic [RW-1:0] r, logic [RW-1:0] w,
                                  logic [RW-1:0] h);
    logic signed [DW+1:0] xs, ys, rs, ws, hs;
    xs = (DW+2)'(x);
    ys = (DW+2)'(y);
    rs = $signed((DW+2)'(r));
    ws = $signed((DW+2)'(w));
    hs = $signed((DW+2)'(h));
    return (xs < -rs) || (xs > ws + rs) || (ys < -rs) || (ys > hs + rs);
  endfunction

  // stage 1
  logic                   off1_q;
  logic signed [DIFW-1:0] dpx_q, dpy_q, wx_q, wy_q;
  logic [RW:0]            r_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      off1_q <= is_off(pair_i.p1x, pair_i.p1y, pair_i.r1, world_width_i, world_height_i)
             || is_off(pair_i.p2x, pair_i.p2y, pair_i.r2, world_width_i, world_height_i);
      dpx_q  <= DIFW'(pair_i.p2x) - DIFW'(pair_i.p1x);
      dpy_q  <= DIFW'(pair_i.p2y) - DIFW'(pair_i.p1y);
      wx_q   <= DIFW'(pair_i.v2x) - DIFW'(pair_i.v1x);
      wy_q   <= DIFW'(pair_i.v2y) - DIFW'(pair_i.v1y);
      r_q    <= (RW+1)'(pair_i.r1) + (RW+1)'(pair_i.r2);
    end
  end

  // stage 2
  logic                  off2_q;
  logic signed [PRW-1:0] xx_q, yy_q, xw_q, yw_q, wxx_q, wyy_q;
  logic [2*RW+1:0]       rr_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      off2_q <= off1_q;
      xx_q   <= dpx_q * dpx_q;
      yy_q   <= dpy_q * dpy_q;
      xw_q   <= dpx_q * wx_q;
      yw_q   <= dpy_q * wy_q;
      wxx_q  <= wx_q * wx_q;
      wyy_q  <= wy_q * wy_q;
      rr_q   <= r_q * r_q;
    end
  end

  // stage 3
  logic signed [SW-1:0] pp, dot, vv, na;
  logic                 done;
  outcome_e             code;
  quad_t                quad_q;

  always_comb begin
    pp  = SW'(xx_q) + SW'(yy_q) - $signed(SW'(rr_q));
    dot = SW'(xw_q) + SW'(yw_q);
    vv  = SW'(wxx_q) + SW'(wyy_q);
    na  = -dot;
    done = 1'b1;
    code = OUT_OFFSCREEN;
    if (off2_q) begin
      code = OUT_OFFSCREEN;
    end else if (pp < 0) begin
      code = OUT_OVERLAP;
    end else if ((step_seconds_i == '0) || (dot >= 0)) begin
      code = OUT_SEPARATE;
    end else begin
      done = 1'b0;
      code = OUT_DISC_MISS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      quad_q.done <= done;
      quad_q.code <= code;
      quad_q.n    <= na[MW-1:0];
      quad_q.up   <= pp[MW-1:0];
      quad_q.uv   <= vv[MW-1:0];
    end
  end

  assign quad_o = quad_q;

endmodule

FILE: sv/scct_wide.sv
`timescale 1ns / 1ps
// wide products of the quadratic tests, split into 17-bit partial products
module scct_wide import scct_pkg::*; (
  input  logic           clk_i,
  input  logic [3:0]     en_i,
  input  logic [STW-1:0] step_seconds_i,
  input  quad_t          quad_i,
  output cmp_t           cmp_o
);

  // stage 4: partial products
  logic                 done4_q;
  outcome_e             code4_q;
  logic [MW-1:0]        up4_q, uv4_q, n4_q;
  logic [STW+LOW-1:0]   suv_lo_q, sn_lo_q;
  logic [STW+HIW-1:0]   suv_hi_q, sn_hi_q;
  logic [2*STW-1:0]     ss4_q;
  logic [2*LOW-1:0]     nn_ll_q, pv_ll_q;
  logic [LOW+HIW-1:0]   nn_lh_q, pv_lh_q, pv_hl_q;
  logic [2*HIW-1:0]     nn_hh_q, pv_hh_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      done4_q  <= quad_i.done;
      code4_q  <= quad_i.code;
      up4_q    <= quad_i.up;
      uv4_q    <= quad_i.uv;
      n4_q     <= quad_i.n;
      suv_lo_q <= step_seconds_i * quad_i.uv[LOW-1:0];
      suv_hi_q <= step_seconds_i * quad_i.uv[MW-1:LOW];
      sn_lo_q  <= step_seconds_i * quad_i.n[LOW-1:0];
      sn_hi_q  <= step_seconds_i * quad_i.n[MW-1:LOW];
      ss4_q    <= step_seconds_i * step_seconds_i;
      nn_ll_q  <= quad_i.n[LOW-1:0] * quad_i.n[LOW-1:0];
      nn_lh_q  <= quad_i.n[LOW-1:0] * quad_i.n[MW-1:LOW];
      nn_hh_q  <= quad_i.n[MW-1:LOW] * quad_i.n[MW-1:LOW];
      pv_ll_q  <= quad_i.up[LOW-1:0] * quad_i.uv[LOW-1:0];
      pv_lh_q  <= quad_i.up[LOW-1:0] * quad_i.uv[MW-1:LOW];
      pv_hl_q  <= quad_i.up[MW-1:LOW] * quad_i.uv[LOW-1:0];
      pv_hh_q  <= quad_i.up[MW-1:LOW] * quad_i.uv[MW-1:LOW];
    end
  end

  // stage 5: recombine
  logic             done5_q;
  outcome_e         code5_q;
  logic [MW-1:0]    up5_q, uv5_q, n5_q;
  logic [SNW-1:0]   suv_q, sn5_q;
  logic [2*STW-1:0] ss5_q;
  logic [NNW-1:0]   nn_q, puv_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      done5_q <= done4_q;
      code5_q <= code4_q;
      up5_q   <= up4_q;
      uv5_q   <= uv4_q;
      n5_q    <= n4_q;
      ss5_q   <= ss4_q;
      suv_q   <= SNW'({suv_hi_q, {LOW{1'b0}}}) + SNW'(suv_lo_q);
      sn5_q   <= SNW'({sn_hi_q, {LOW{1'b0}}}) + SNW'(sn_lo_q);
      nn_q    <= NNW'(nn_ll_q) + NNW'({nn_lh_q, 1'b0, {LOW{1'b0}}})
               + NNW'({nn_hh_q, {2*LOW{1'b0}}});
      puv_q   <= NNW'(pv_ll_q) + NNW'({pv_lh_q, {LOW{1'b0}}})
               + NNW'({pv_hl_q, {LOW{1'b0}}}) + NNW'({pv_hh_q, {2*LOW{1'b0}}});
    end
  end

  // stage 6: end-of-step test, discriminant sign, s*s*v halves
  logic                   done6_q, c1_q, disc_q;
  outcome_e               code6_q;
  logic [MW-1:0]          up6_q;
  logic [SNW-1:0]         sn6_q;
  logic [2*STW+LOW-1:0]   m_lo_q;
  logic [2*STW+HIW-1:0]   m_hi_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      done6_q <= done5_q;
      code6_q <= code5_q;
      up6_q   <= up5_q;
      sn6_q   <= sn5_q;
      c1_q    <= suv_q <= {n5_q, {STW{1'b0}}};
      disc_q  <= nn_q > puv_q;
      m_lo_q  <= ss5_q * uv5_q[LOW-1:0];
      m_hi_q  <= ss5_q * uv5_q[MW-1:LOW];
    end
  end

  // stage 7: s*s*v + p*2^32
  cmp_t cmp_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      cmp_q.done <= done6_q;
      cmp_q.code <= code6_q;
      cmp_q.c1   <= c1_q;
      cmp_q.disc <= disc_q;
      cmp_q.sn   <= sn6_q;
      cmp_q.lhs  <= SUMW'(m_lo_q) + SUMW'({m_hi_q, {LOW{1'b0}}})
                  + SUMW'({up6_q, {2*STW{1'b0}}});
    end
  end

  assign cmp_o = cmp_q;

endmodule

FILE: sv/scct_decide.sv
`timescale 1ns / 1ps
// final stage: closest-approach test and the output register
module scct_decide import scct_pkg::*; (
  input  logic     clk_i,
  input  logic     en_i,
  input  cmp_t     cmp_i,
  output logic     hit_o,
  output outcome_e outcome_o
);

  logic     c2;
  outcome_e code;
  logic     hit_q;
  outcome_e outcome_q;

  always_comb begin
    c2 = cmp_i.lhs >= SUMW'({cmp_i.sn, {RSH{1'b0}}});
    if (cmp_i.done) begin
      code = cmp_i.code;
    end else if (cmp_i.c1 && c2) begin
      code = OUT_CLEAR;
    end else if (cmp_i.disc) begin
      code = OUT_DISC_HIT;
    end else begin
      code = OUT_DISC_MISS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      outcome_q <= code;
      hit_q     <= (code == OUT_OVERLAP) || (code == OUT_DISC_HIT);
    end
  end

  assign hit_o     = hit_q;
  assign outcome_o = outcome_q;

endmodule

FILE: sv/swept_circle_collision_test_top.sv
`timescale 1ns / 1ps
// top level of the swept circle collision test pipeline
//
// usage
//   input channel: one item is a pair of moving circles (centre, velocity,
//   radius each), taken at a rising edge with in_valid_i high and in_stall_o
//   low. output channel: one item per input item (hit_o, outcome_o), taken
//   with out_valid_o high and out_stall_i low. results leave in input order.
//   config channel: cfg_index_i selects world width (0), world height (1) or
//   step time (2); other indexes are ignored. cfg_ready_o is always high.
//   write config only while the pipeline is empty.
//   stages: an accepted item passes through eight register stages on its way
//   to out_valid_o (front geometry, split wide multiplies, final compare).
//   throughput: one item per cycle; every stage is a register with its own
//   valid bit, so an item enters each cycle when nothing downstream stalls.
//   stall: a stalled result holds in the output register; earlier stages keep
//   filling any empty slots, and in_stall_o rises only once the pipe is full.
//   reset: clears all valid bits and loads the default world size and step.
module swept_circle_collision_test_top import scct_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input item channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] first_pos_x_i,
  input  logic [COORD_BITS-1:0] first_pos_y_i,
  input  logic [COORD_BITS-1:0] first_vel_x_i,
  input  logic [COORD_BITS-1:0] first_vel_y_i,
  input  logic [RW-1:0]         first_radius_i,
  input  logic [COORD_BITS-1:0] second_pos_x_i,
  input  logic [COORD_BITS-1:0] second_pos_y_i,
  input  logic [COORD_BITS-1:0] second_vel_x_i,
  input  logic [COORD_BITS-1:0] second_vel_y_i,
  input  logic [RW-1:0]         second_radius_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o,
  output logic [2:0]            outcome_o,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [STW-1:0]        cfg_data_i
);

  // only the low bits up to the datapath width are used
  localparam int DATA_BITS = (COORD_BITS > DW) ? DW : COORD_BITS;
  localparam int NST       = 8;

  localparam logic [1:0] CFG_WORLD_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_WORLD_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_STEP_SECONDS = 2'd2;

  localparam logic [RW-1:0]  WIDTH_RESET  = 15'd12800;
  localparam logic [RW-1:0]  HEIGHT_RESET = 15'd9600;
  localparam logic [STW-1:0] STEP_RESET   = 16'd1092;

  // configuration registers
  logic [RW-1:0]  world_width_q, world_height_q;
  logic [STW-1:0] step_seconds_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      world_width_q  <= WIDTH_RESET;
      world_height_q <= HEIGHT_RESET;
      step_seconds_q <= STEP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_WORLD_WIDTH:  world_width_q  <= cfg_data_i[RW-1:0];
        CFG_WORLD_HEIGHT: world_height_q <= cfg_data_i[RW-1:0];
        CFG_STEP_SECONDS: step_seconds_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid bits and per-stage advance; a stage loads when it is empty or
  // the stage after it moves on
  logic [NST-1:0] vld_q, vld_d, rdy;

  always_comb begin
    rdy[NST-1] = !vld_q[NST-1] || !out_stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    for (int k = 0; k < NST; k++) begin
      if (k == 0) begin
        vld_d[k] = rdy[k] ? in_valid_i : vld_q[k];
      end else begin
        vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NST-1];

  // sign-extend the item fields to the datapath width
  pair_t pair;

  always_comb begin
    pair.p1x = DW'($signed(first_pos_x_i[DATA_BITS-1:0]));
    pair.p1y = DW'($signed(first_pos_y_i[DATA_BITS-1:0]));
    pair.v1x = DW'($signed(first_vel_x_i[DATA_BITS-1:0]));
    pair.v1y = DW'($signed(first_vel_y_i[DATA_BITS-1:0]));
    pair.r1  = first_radius_i;
    pair.p2x = DW'($signed(second_pos_x_i[DATA_BITS-1:0]));
    pair.p2y = DW'($signed(second_pos_y_i[DATA_BITS-1:0]));
    pair.v2x = DW'($signed(second_vel_x_i[DATA_BITS-1:0]));
    pair.v2y = DW'($signed(second_vel_y_i[DATA_BITS-1:0]));
    pair.r2  = second_radius_i;
  end

  quad_t    quad;
  cmp_t     cmp;
  outcome_e outcome;

  // stages 1 to 3: offscreen, relative motion, dot products, early outcome
  scct_geom u_geom (
    .clk_i          (clk_i),
    .en_i           (rdy[2:0]),
    .pair_i         (pair),
    .world_width_i  (world_width_q),
    .world_height_i (world_height_q),
    .step_seconds_i (step_seconds_q),
    .quad_o         (quad)
  );

  // stages 4 to 7: exact wide products of the quadratic tests
  scct_wide u_wide (
    .clk_i          (clk_i),
    .en_i           (rdy[6:3]),
    .step_seconds_i (step_seconds_q),
    .quad_i         (quad),
    .cmp_o          (cmp)
  );

  // stage 8: final compare into the output register
  scct_decide u_decide (
    .clk_i     (clk_i),
    .en_i      (rdy[7]),
    .cmp_i     (cmp),
    .hit_o     (hit_o),
    .outcome_o (outcome)
  );

  assign outcome_o = outcome;

  // hit flag agrees with the outcome code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_o == ((outcome_o == OUT_OVERLAP) || (outcome_o == OUT_DISC_HIT))))
    else $error("hit flag disagrees with outcome");

  // a full pipe with a stalled result pushes back on the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&vld_q) && out_stall_i) |-> in_stall_o)
    else $error("input taken while pipeline full and stalled");

  // an accepted item occupies the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted item lost at entry");

  // a taken result with nothing behind it is not shown again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !vld_q[NST-2]) |=> !out_valid_o)
    else $error("result repeated");

endmodule
